@@ design/rgb_pixel_format_converter_core_assert.svh @@
// Assertion macros for the packed RGB pixel format converter.
// Used by the port checker; needs nothing else.
`ifndef RGB_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define RGB_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define RGBPFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RGBPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rgbpfc_pkg.sv @@
// Shared types, register indexes and channel mapping functions for the
// packed RGB pixel format converter. No dependencies.
`default_nettype none

package rgbpfc_pkg;

    localparam int BYTES_W  = 3;
    localparam int LAYOUT_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_BYTES   = 3'd0,
        CFG_DST_BYTES   = 3'd1,
        CFG_SRC_RED     = 3'd2,
        CFG_SRC_GREEN   = 3'd3,
        CFG_SRC_BLUE    = 3'd4,
        CFG_DST_RED     = 3'd5,
        CFG_DST_GREEN   = 3'd6,
        CFG_DST_BLUE    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LAYOUT_W-1:0] src_red;
        logic [LAYOUT_W-1:0] src_green;
        logic [LAYOUT_W-1:0] src_blue;
        logic [LAYOUT_W-1:0] dst_red;
        logic [LAYOUT_W-1:0] dst_green;
        logic [LAYOUT_W-1:0] dst_blue;
    } t_layouts;

    localparam logic [BYTES_W-1:0]  RST_BYTES   = 3'd4;
    localparam logic [LAYOUT_W-1:0] RST_RED     = 10'd520;
    localparam logic [LAYOUT_W-1:0] RST_GREEN   = 10'd264;
    localparam logic [LAYOUT_W-1:0] RST_BLUE    = 10'd8;

    // Zero acts as one, five to seven act as four.
    function automatic logic [BYTES_W-1:0] clamp_bytes(input logic [BYTES_W-1:0] n);
        logic [BYTES_W-1:0] r;
        if (n == 3'd0) begin
            r = 3'd1;
        end else if (n > 3'd4) begin
            r = 3'd4;
        end else begin
            r = n;
        end
        return r;
    endfunction

    // Extract, rescale and place one channel; bits past bit 31 drop off.
    function automatic logic [WORD_W-1:0] map_channel(input logic [WORD_W-1:0] px,
                                                     input logic [LAYOUT_W-1:0] sl,
                                                     input logic [LAYOUT_W-1:0] dl);
        logic [4:0]        ssh;
        logic [4:0]        ssz;
        logic [4:0]        dsh;
        logic [4:0]        dsz;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] v;
        ssh  = sl[9:5];
        ssz  = sl[4:0];
        dsh  = dl[9:5];
        dsz  = dl[4:0];
        mask = (32'd1 << ssz) - 32'd1;
        v    = (px >> ssh) & mask;
        v    = v << dsz;
        v    = v >> ssz;
        v    = v << dsh;
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/rgbpfc_convert.sv @@
// Channel remapper: turns one gathered source word into a destination word.
// Depends on rgbpfc_pkg.
`default_nettype none

module rgbpfc_convert
    import rgbpfc_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_word,
    input  wire t_layouts          i_layouts,
    output logic [WORD_W-1:0]      o_pixel
);

    // Alpha and padding come out zero since only three channels are ORed.
    assign o_pixel = map_channel(i_word, i_layouts.src_red,   i_layouts.dst_red)
                   | map_channel(i_word, i_layouts.src_green, i_layouts.dst_green)
                   | map_channel(i_word, i_layouts.src_blue,  i_layouts.dst_blue);

endmodule

`default_nettype wire

@@ design/rgb_pixel_format_converter_core.sv @@
// Packed RGB pixel format converter: byte gatherer, channel remap, byte serializer.
// The first destination byte passes through the pixel buffer and the output
// register on its way to m_axis. Throughput: one byte per cycle on each side
// unless a side stalls; the gatherer collects the next pixel while the single
// pixel buffer feeding the serializer holds the last. Reset (synchronous, active
// low) clears the gatherer, empties both stages and loads default register values.
`default_nettype none

module rgb_pixel_format_converter_core
    import rgbpfc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [LAYOUT_W-1:0]   i_cfg_wdata,
    // source byte stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  wire logic                  s_axis_tlast,   // end_of_run
    // destination byte stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast,   // pixel_last
    output logic                       m_axis_tuser    // run_last
);

    // configuration registers
    logic [BYTES_W-1:0] r_src_bytes;
    logic [BYTES_W-1:0] r_dst_bytes;
    t_layouts           r_layouts;

    // gatherer
    logic [WORD_W-1:0]  r_acc;
    logic [1:0]         r_cnt;

    // pixel buffer and serializer
    logic               r_pix_vld;
    logic [WORD_W-1:0]  r_pix;
    logic [1:0]         r_k;
    logic [1:0]         r_dn_m1;
    logic               r_eor;

    // output register
    logic               r_out_vld;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_run;

    logic [BYTES_W-1:0] sn;
    logic [BYTES_W-1:0] dn;
    logic [WORD_W-1:0]  n_word;
    logic [WORD_W-1:0]  conv;
    logic               completes;
    logic               ser_move;
    logic               ser_last;
    logic               pix_free;
    logic               in_acc;

    rgbpfc_convert u_convert (
        .i_word    (n_word),
        .i_layouts (r_layouts),
        .o_pixel   (conv)
    );

    always_comb begin
        sn        = clamp_bytes(r_src_bytes);
        dn        = clamp_bytes(r_dst_bytes);
        n_word    = r_acc | ({24'd0, s_axis_tdata} << {r_cnt, 3'b000});
        completes = (({1'b0, r_cnt} + 3'd1) >= sn) || s_axis_tlast;
        ser_move  = r_pix_vld && (!r_out_vld || m_axis_tready);
        ser_last  = (r_k == r_dn_m1);
        pix_free  = !r_pix_vld || (ser_move && ser_last);
        in_acc    = s_axis_tvalid && s_axis_tready;
    end

    // A byte that closes a pixel waits for the pixel buffer; others always go in.
    assign s_axis_tready = !completes || pix_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_bytes         <= RST_BYTES;
            r_dst_bytes         <= RST_BYTES;
            r_layouts.src_red   <= RST_RED;
            r_layouts.src_green <= RST_GREEN;
            r_layouts.src_blue  <= RST_BLUE;
            r_layouts.dst_red   <= RST_RED;
            r_layouts.dst_green <= RST_GREEN;
            r_layouts.dst_blue  <= RST_BLUE;
            r_acc               <= '0;
            r_cnt               <= '0;
            r_pix_vld           <= 1'b0;
            r_k                 <= '0;
            r_out_vld           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SRC_BYTES: r_src_bytes         <= i_cfg_wdata[BYTES_W-1:0];
                    CFG_DST_BYTES: r_dst_bytes         <= i_cfg_wdata[BYTES_W-1:0];
                    CFG_SRC_RED:   r_layouts.src_red   <= i_cfg_wdata;
                    CFG_SRC_GREEN: r_layouts.src_green <= i_cfg_wdata;
                    CFG_SRC_BLUE:  r_layouts.src_blue  <= i_cfg_wdata;
                    CFG_DST_RED:   r_layouts.dst_red   <= i_cfg_wdata;
                    CFG_DST_GREEN: r_layouts.dst_green <= i_cfg_wdata;
                    CFG_DST_BLUE:  r_layouts.dst_blue  <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (in_acc) begin
                if (completes) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= n_word;
                    r_cnt <= r_cnt + 2'd1;
                end
            end

            if (ser_move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            // advance the serializer, then let a fresh pixel take over the buffer
            if (ser_move) begin
                if (ser_last) begin
                    r_pix_vld <= 1'b0;
                    r_k       <= '0;
                end else begin
                    r_k       <= r_k + 2'd1;
                end
            end
            if (in_acc && completes) begin
                r_pix_vld <= 1'b1;
                r_k       <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && completes) begin
            r_pix   <= conv;
            r_dn_m1 <= 2'(dn - 3'd1);
            r_eor   <= s_axis_tlast;
        end
        if (ser_move) begin
            r_out_byte <= r_pix[{r_k, 3'b000} +: 8];
            r_out_last <= ser_last;
            r_out_run  <= ser_last && r_eor;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_run;

endmodule

`default_nettype wire

@@ design/rgbpfc_checker.sv @@
// Port-level checker for the packed RGB pixel format converter, bound to the top.
// Depends on rgb_pixel_format_converter_core_assert.svh.
`default_nettype none

`include "rgb_pixel_format_converter_core_assert.svh"

module rgbpfc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);

    logic       in_run_end;
    logic       out_stall;
    logic       out_run;
    logic [9:0] out_bus;

    assign in_run_end = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_run    = m_axis_tvalid && m_axis_tuser;
    assign out_bus    = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

    // Nothing leaves the block the cycle after reset.
    `RGBPFC_ASSERT(a_empty_after_reset, i_clk, i_rst_n,
        $past(!i_rst_n) |-> !m_axis_tvalid, "output valid right after reset")

    // End of run only ever marks the last byte of a pixel.
    `RGBPFC_ASSERT(a_run_on_pixel_end, i_clk, i_rst_n,
        out_run |-> m_axis_tlast, "run_last without pixel_last")

    // A stalled output byte holds.
    `RGBPFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        out_stall, m_axis_tvalid && $stable(out_bus), "stalled output changed")

    // A request that ends a run always leads to valid output on m_axis.
    `RGBPFC_ASSERT_NEXT(a_run_emits, i_clk, i_rst_n,
        in_run_end, ##1 m_axis_tvalid, "run end produced no output")

endmodule

bind rgb_pixel_format_converter_core rgbpfc_checker u_rgbpfc_checker (.*);

`default_nettype wire
